// ===== rtl/text_console_char_writer_top_assert.svh =====
// Assertion macros for the text console character writer.
`ifndef TEXT_CONSOLE_CHAR_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types and constants of the text console character writer.
package tcw_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_PUT    = 2'd0;
    localparam logic [1:0] CMD_CLEAR  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_REDRAW = 2'd3;

    // control characters of a put
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_RETURN    = 8'd13;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QUEUE_PTR_W-1:0] QUEUE_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

    // request class decided by the front end
    typedef enum logic [2:0] {
        K_NEWLINE,
        K_RETURN,
        K_BACKSPACE,
        K_PRINT,
        K_CLEAR,
        K_READ,
        K_REDRAW
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [5:0] read_col;
    } req_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } qitem_t;

endpackage

// ===== rtl/tcw_front.sv =====
// Front end: takes input requests and classifies them for the queue.
module tcw_front (
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [tcw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [tcw_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    input  logic                             q_full,
    output tcw_pkg::qitem_t                  push_item
);
    import tcw_pkg::*;

    assign s_axis_tready = !q_full;

    always_comb
    begin
        push_item.valid         = s_axis_tvalid && !q_full;
        push_item.req.char_code = s_axis_tdata[7:0];
        push_item.req.read_row  = s_axis_tdata[12:8];
        push_item.req.read_col  = s_axis_tdata[18:13];
        case (s_axis_tuser)
            CMD_PUT:
            begin
                case (s_axis_tdata[7:0])
                    CHAR_NEWLINE:   push_item.req.kind = K_NEWLINE;
                    CHAR_RETURN:    push_item.req.kind = K_RETURN;
                    CHAR_BACKSPACE: push_item.req.kind = K_BACKSPACE;
                    default:        push_item.req.kind = K_PRINT;
                endcase
            end
            CMD_CLEAR:  push_item.req.kind = K_CLEAR;
            CMD_READ:   push_item.req.kind = K_READ;
            CMD_REDRAW: push_item.req.kind = K_REDRAW;
            default:    push_item.req.kind = K_REDRAW;
        endcase
    end

endmodule

// ===== rtl/tcw_queue.sv =====
// Short request queue between the front end and the back end.
module tcw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  tcw_pkg::qitem_t push_item,
    output logic            full,
    input  logic            pop,
    output tcw_pkg::qitem_t head
);
    import tcw_pkg::*;

    req_t                   slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   do_push, do_pop;

    assign full       = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.req   = slot_reg[rd_ptr_reg];
    assign do_push    = push_item.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item.req;
    end

endmodule

// ===== rtl/tcw_back.sv =====
// Back end: cursor, dirty range, row ring and grid memory; builds results.
module tcw_back #(
    parameter int COLUMNS     = 40,
    parameter int SCROLL_ROWS = 26
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tcw_pkg::qitem_t                   head,
    output logic                              pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [tcw_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import tcw_pkg::*;

    localparam int ROW_CELLS  = COLUMNS + 1;
    localparam int GRID_CELLS = SCROLL_ROWS * ROW_CELLS;
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int RW = $clog2(SCROLL_ROWS + 1);
    localparam int PW = $clog2(SCROLL_ROWS);
    localparam int AW = $clog2(GRID_CELLS);

    localparam logic [CW-1:0] COLS_C    = CW'(COLUMNS);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROWS_C    = RW'(SCROLL_ROWS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(SCROLL_ROWS - 1);
    localparam logic [PW-1:0] LAST_PHYS = PW'(SCROLL_ROWS - 1);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PREP  = 8'b0000_0010,
        ST_ADDR  = 8'b0000_0100,
        ST_WRITE = 8'b0000_1000,
        ST_POST  = 8'b0001_0000,
        ST_RADDR = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    // logical row -> physical row of the ring
    function automatic logic [PW-1:0] phys_row(input logic [RW-1:0] lrow,
                                               input logic [PW-1:0] base);
        logic [RW:0] sum;
        sum = (RW+1)'(lrow) + (RW+1)'(base);
        if (sum >= (RW+1)'(SCROLL_ROWS))
            sum = sum - (RW+1)'(SCROLL_ROWS);
        return PW'(sum);
    endfunction

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cur_col_reg, cur_col_next;
    logic [RW-1:0]          cur_row_reg, cur_row_next;
    logic [RW-1:0]          dirty_lo_reg, dirty_lo_next;
    logic [RW-1:0]          dirty_hi_reg, dirty_hi_next;
    logic                   full_reg, full_next;
    logic [PW-1:0]          base_reg, base_next;
    logic [SCROLL_ROWS-1:0] row_valid_reg, row_valid_next;
    logic                   out_valid_reg, out_valid_next;

    req_t                   req_reg, req_next;
    logic [CW-1:0]          wr_col_reg, wr_col_next;
    logic [7:0]             wr_val_reg, wr_val_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          idx_end_reg, idx_end_next;
    logic [AW-1:0]          row_base_reg, row_base_next;
    logic                   rd_ok_reg, rd_ok_next;
    logic [7:0]             cell_reg, cell_next;
    logic [OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    logic [7:0]             grid_mem [GRID_CELLS];
    logic [7:0]             rd_data_reg;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          waddr, raddr;
    logic [7:0]             wdata;

    logic [RW-1:0]          mark_lo, mark_hi;
    logic [PW-1:0]          cur_phys, rd_phys;
    logic                   rd_in_range;

    // dirty range widened to the cursor row
    assign mark_lo  = (cur_row_reg < dirty_lo_reg) ? cur_row_reg : dirty_lo_reg;
    assign mark_hi  = (cur_row_reg > dirty_hi_reg) ? cur_row_reg : dirty_hi_reg;
    assign cur_phys = phys_row(cur_row_reg, base_reg);
    assign rd_phys  = phys_row(RW'(req_reg.read_row), base_reg);
    assign rd_in_range = (int'(req_reg.read_row) < SCROLL_ROWS) &&
                         (int'(req_reg.read_col) < ROW_CELLS);

    assign waddr = row_base_reg + AW'(idx_reg);
    assign wdata = (idx_reg == wr_col_reg) ? wr_val_reg : 8'd0;
    assign raddr = AW'(rd_phys) * AW'(ROW_CELLS) + AW'(req_reg.read_col);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next     = state_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        dirty_lo_next  = dirty_lo_reg;
        dirty_hi_next  = dirty_hi_reg;
        full_next      = full_reg;
        base_next      = base_reg;
        row_valid_next = row_valid_reg;
        req_next       = req_reg;
        wr_col_next    = wr_col_reg;
        wr_val_next    = wr_val_reg;
        idx_next       = idx_reg;
        idx_end_next   = idx_end_reg;
        row_base_next  = row_base_reg;
        rd_ok_next     = rd_ok_reg;
        cell_next      = cell_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    req_next  = head.req;
                    cell_next = 8'd0;
                    case (head.req.kind)
                        K_CLEAR:
                        begin
                            row_valid_next = '0;
                            base_next      = '0;
                            cur_col_next   = '0;
                            cur_row_next   = '0;
                            full_next      = 1'b1;
                            dirty_lo_next  = '0;
                            dirty_hi_next  = LAST_ROW;
                            state_next     = ST_DONE;
                        end
                        K_REDRAW:
                        begin
                            if (full_reg)
                            begin
                                full_next     = 1'b0;
                                dirty_lo_next = '0;
                                dirty_hi_next = LAST_ROW;
                            end
                            else
                            begin
                                dirty_lo_next = ROWS_C;
                                dirty_hi_next = '0;
                            end
                            state_next = ST_DONE;
                        end
                        K_READ:  state_next = ST_RADDR;
                        default: state_next = ST_PREP;
                    endcase
                end
            end

            ST_PREP:
            begin
                if (cur_row_reg >= ROWS_C)
                begin
                    // pending scroll: old top row becomes the blank bottom row
                    row_valid_next[base_reg] = 1'b0;
                    base_next     = (base_reg == LAST_PHYS) ? '0 : base_reg + 1'b1;
                    cur_row_next  = LAST_ROW;
                    full_next     = 1'b1;
                    dirty_lo_next = '0;
                    dirty_hi_next = LAST_ROW;
                end
                else
                begin
                    dirty_lo_next = mark_lo;
                    dirty_hi_next = mark_hi;
                    case (req_reg.kind)
                        K_NEWLINE:
                        begin
                            cur_col_next = '0;
                            cur_row_next = cur_row_reg + 1'b1;
                            state_next   = ST_POST;
                        end
                        K_RETURN:
                        begin
                            cur_col_next = '0;
                            state_next   = ST_ADDR;
                        end
                        K_BACKSPACE:
                        begin
                            wr_val_next = 8'd0;
                            if (cur_col_reg != '0)
                            begin
                                cur_col_next = cur_col_reg - 1'b1;
                                wr_col_next  = cur_col_reg - 1'b1;
                                state_next   = ST_ADDR;
                            end
                            else if (cur_row_reg != '0)
                            begin
                                cur_row_next = cur_row_reg - 1'b1;
                                cur_col_next = LAST_COL;
                                wr_col_next  = LAST_COL;
                                state_next   = ST_ADDR;
                            end
                            else
                                state_next = ST_POST;
                        end
                        default:
                        begin
                            wr_val_next = req_reg.char_code;
                            if (cur_col_reg >= COLS_C)
                            begin
                                wr_col_next  = '0;
                                cur_col_next = CW'(1);
                                if (cur_row_reg == LAST_ROW)
                                begin
                                    // wrap off the last row scrolls right away
                                    row_valid_next[base_reg] = 1'b0;
                                    base_next = (base_reg == LAST_PHYS) ? '0
                                                                        : base_reg + 1'b1;
                                    full_next     = 1'b1;
                                    dirty_lo_next = '0;
                                    dirty_hi_next = LAST_ROW;
                                end
                                else
                                    cur_row_next = cur_row_reg + 1'b1;
                            end
                            else
                            begin
                                wr_col_next  = cur_col_reg;
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                            state_next = ST_ADDR;
                        end
                    endcase
                end
            end

            ST_ADDR:
            begin
                row_base_next = AW'(cur_phys) * AW'(ROW_CELLS);
                case (req_reg.kind)
                    K_RETURN:
                    begin
                        row_valid_next[cur_phys] = 1'b0;
                        state_next = ST_POST;
                    end
                    K_BACKSPACE:
                    begin
                        // a blank row already reads zero
                        idx_next     = wr_col_reg;
                        idx_end_next = wr_col_reg;
                        state_next   = row_valid_reg[cur_phys] ? ST_WRITE : ST_POST;
                    end
                    default:
                    begin
                        if (row_valid_reg[cur_phys])
                        begin
                            idx_next     = wr_col_reg;
                            idx_end_next = wr_col_reg + 1'b1;
                        end
                        else
                        begin
                            // first write to a blank row sweeps the whole row
                            idx_next     = '0;
                            idx_end_next = COLS_C;
                        end
                        row_valid_next[cur_phys] = 1'b1;
                        state_next = ST_WRITE;
                    end
                endcase
            end

            ST_WRITE:
            begin
                mem_we = 1'b1;
                if (idx_reg == idx_end_reg)
                    state_next = ST_POST;
                else
                    idx_next = idx_reg + 1'b1;
            end

            ST_POST:
            begin
                dirty_lo_next = mark_lo;
                dirty_hi_next = mark_hi;
                state_next    = ST_DONE;
            end

            ST_RADDR:
            begin
                rd_ok_next = rd_in_range && row_valid_reg[rd_phys];
                mem_re     = rd_in_range;
                state_next = ST_READ;
            end

            ST_READ:
            begin
                cell_next  = rd_ok_reg ? rd_data_reg : 8'd0;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {2'b00, cell_reg, full_reg, 5'(dirty_hi_reg),
                                      5'(dirty_lo_reg), 5'(cur_row_reg), 6'(cur_col_reg)};
                    state_next     = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            dirty_lo_reg  <= '0;
            dirty_hi_reg  <= LAST_ROW;
            full_reg      <= 1'b1;
            base_reg      <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            dirty_lo_reg  <= dirty_lo_next;
            dirty_hi_reg  <= dirty_hi_next;
            full_reg      <= full_next;
            base_reg      <= base_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        wr_col_reg   <= wr_col_next;
        wr_val_reg   <= wr_val_next;
        idx_reg      <= idx_next;
        idx_end_reg  <= idx_end_next;
        row_base_reg <= row_base_next;
        rd_ok_reg    <= rd_ok_next;
        cell_reg     <= cell_next;
        out_data_reg <= out_data_next;
    end

    // grid memory: one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[waddr] <= wdata;
        if (mem_re)
            rd_data_reg <= grid_mem[raddr];
    end

endmodule

// ===== rtl/text_console_char_writer_top.sv =====
// Top level of the text console character writer.
//
//   port group   dir   tdata fields (low bit up)                 tuser
//   s_axis_*     in    char_code, read_row, read_col, pad        command
//   m_axis_*     out   cursor_col, cursor_row, dirty_first,      -
//                      dirty_last, redraw_all, cell_char, pad
//
// In the back end, clear and redraw go straight to the result, a read passes
// the address and read states, and a put the prepare, address, write and
// post states as it needs them; a pending scroll adds a prepare pass. The
// grid memory's single write port, one cell per cycle, makes a printable
// character landing in a blank row, which it sweeps, the longest case.
// Scrolling rotates a row ring and blanks rows through per-row valid bits,
// so reset needs no clearing pass and the block takes requests right after
// reset. Two requests queue ahead of the back end, and a finished result
// waits in the output register without blocking the front end.
`include "text_console_char_writer_top_assert.svh"

module text_console_char_writer_top #(
    parameter int COLUMNS     = 40,
    parameter int SCROLL_ROWS = 26
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // char_code[7:0], read_row[12:8], read_col[18:13], zero pad [23:19]
    input  logic [tcw_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // command[1:0]
    input  logic [tcw_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    // result channel
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // cursor_col[5:0], cursor_row[10:6], dirty_first[15:11],
    // dirty_last[20:16], redraw_all[21], cell_char[29:22], zero pad [31:30]
    output logic [tcw_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import tcw_pkg::*;

    qitem_t push_item;
    qitem_t q_head;
    logic   q_full;
    logic   q_pop;

    // classify incoming requests
    tcw_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .push_item     (push_item)
    );

    // decouples intake from the multi-cycle back end
    tcw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head)
    );

    // grid, cursor and dirty tracking plus the output register
    tcw_back #(
        .COLUMNS     (COLUMNS),
        .SCROLL_ROWS (SCROLL_ROWS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // back end only pops a request that is there
    `TCW_ASSERT_IMP(a_pop_nonempty, q_pop, q_head.valid, "pop from empty request queue")
    // one request at a time: a pop is never followed at once by another pop
    `TCW_ASSERT_NEXT(a_pop_single, q_pop, !q_pop, "back end popped twice in a row")
    // cursor stays inside the grid, with one pending-wrap column and one pending-scroll row
    `TCW_ASSERT_IMP(a_cursor_range, m_axis_tvalid, (m_axis_tdata[5:0] <= COLUMNS) && (m_axis_tdata[10:6] <= SCROLL_ROWS), "cursor out of range")
    // a full redraw always covers the top row
    `TCW_ASSERT_IMP(a_full_dirty, m_axis_tvalid && m_axis_tdata[21], m_axis_tdata[15:11] == 5'd0, "full redraw without top row dirty")

endmodule

// ===== test/tb_text_console_char_writer_top.sv =====
// Self-checking testbench for the text console character writer top level.
`timescale 1ns / 1ps

module tb_text_console_char_writer_top;

    import tcw_pkg::*;

    // Grid geometry, kept at the block's defaults.
    localparam int COLS      = 40;
    localparam int ROWS      = 26;
    localparam int ROW_CELLS = COLS + 1;

    localparam int RANDOM_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 1000000;
    // Longest back-end request is a print that sweeps a blank row after a pending scroll.
    localparam int DRAIN_CYCLES = 60;

    // One result, laid out as m_axis_tdata[29:0] (last field is the lowest bits).
    typedef struct packed {
        logic [7:0] cell_char;
        logic       redraw_all;
        logic [4:0] dirty_last;
        logic [4:0] dirty_first;
        logic [4:0] cursor_row;
        logic [5:0] cursor_col;
    } status_t;

    // One row of the directed table. When known is set the golden status is
    // the expectation; otherwise the grid model supplies it.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [4:0] rrow;
        logic [5:0] rcol;
        logic       known;
        status_t    golden;
    } stim_step_t;

    typedef struct packed {
        logic    known;
        status_t golden;
    } req_note_t;

    // Golden fields are written as {cell_char, redraw_all, dirty_last,
    // dirty_first, cursor_row, cursor_col}.
    localparam int SCRIPT_LEN = 25;
    localparam stim_step_t SCRIPT [SCRIPT_LEN] = '{
        // fresh grid: read a cell, acknowledge the full redraw, then redraw with nothing dirty
        '{CMD_READ,   8'h00, 5'd0,  6'd0,  1'b1, {8'd0, 1'b1, 5'd25, 5'd0,  5'd0, 6'd0}},
        '{CMD_REDRAW, 8'h00, 5'd0,  6'd0,  1'b1, {8'd0, 1'b0, 5'd25, 5'd0,  5'd0, 6'd0}},
        '{CMD_REDRAW, 8'h00, 5'd0,  6'd0,  1'b1, {8'd0, 1'b0, 5'd0,  5'd26, 5'd0, 6'd0}},
        // read with both coordinates at their field maximum reads zero
        '{CMD_READ,   8'h00, 5'd31, 6'd63, 1'b1, {8'd0, 1'b0, 5'd0,  5'd26, 5'd0, 6'd0}},
        // printable bytes including the extremes; a zero byte is stored too
        '{CMD_PUT,    8'h41, 5'd0,  6'd0,  1'b0, '0},
        '{CMD_PUT,    8'hFF, 5'd31, 6'd63, 1'b0, '0},
        '{CMD_PUT,    8'h00, 5'd0,  6'd0,  1'b0, '0},
        '{CMD_PUT,    CHAR_BACKSPACE, 5'd0, 6'd0, 1'b0, '0},
        // newline, then backspace from column 0 wraps to the end of the row above
        '{CMD_PUT,    CHAR_NEWLINE,   5'd0, 6'd0, 1'b0, '0},
        '{CMD_PUT,    CHAR_BACKSPACE, 5'd0, 6'd0, 1'b0, '0},
        // fill the last column, then a byte at the right edge wraps
        '{CMD_PUT,    8'h7E, 5'd0,  6'd0,  1'b0, '0},
        '{CMD_PUT,    8'h5A, 5'd0,  6'd0,  1'b0, '0},
        '{CMD_PUT,    CHAR_RETURN,    5'd0, 6'd0, 1'b0, '0},
        '{CMD_READ,   8'h00, 5'd0,  6'd39, 1'b0, '0},
        // terminator cells and the first coordinates past the grid
        '{CMD_READ,   8'h00, 5'd0,  6'd40, 1'b0, '0},
        '{CMD_READ,   8'h00, 5'd25, 6'd40, 1'b0, '0},
        '{CMD_READ,   8'h00, 5'd0,  6'd41, 1'b0, '0},
        '{CMD_READ,   8'h00, 5'd26, 6'd0,  1'b0, '0},
        // clear, then backspace at the home position changes nothing
        '{CMD_CLEAR,  8'h00, 5'd0,  6'd0,  1'b1, {8'd0, 1'b1, 5'd25, 5'd0,  5'd0, 6'd0}},
        '{CMD_PUT,    CHAR_BACKSPACE, 5'd0, 6'd0, 1'b1, {8'd0, 1'b1, 5'd25, 5'd0, 5'd0, 6'd0}},
        '{CMD_REDRAW, 8'h00, 5'd0,  6'd0,  1'b1, {8'd0, 1'b0, 5'd25, 5'd0,  5'd0, 6'd0}},
        '{CMD_PUT,    CHAR_NEWLINE,   5'd0, 6'd0, 1'b0, '0},
        '{CMD_READ,   8'h00, 5'd21, 6'd42, 1'b0, '0},
        '{CMD_READ,   8'h00, 5'd10, 6'd21, 1'b0, '0},
        '{CMD_REDRAW, 8'h00, 5'd0,  6'd0,  1'b0, '0}
    };

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    text_console_char_writer_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Grid model: its own copy of the cells, cursor and redraw state.
    // ------------------------------------------------------------------
    logic [7:0] screen [ROWS][ROW_CELLS];
    logic [5:0] cur_col;
    logic [4:0] cur_row;
    logic [4:0] dirty_lo;
    logic [4:0] dirty_hi;
    logic       full_flag;

    int scroll_count = 0;
    int wrap_count   = 0;
    int read_count   = 0;

    function automatic void poke(input int unsigned r, input int unsigned c,
                                 input logic [7:0] v);
        if (r < ROWS && c < ROW_CELLS)
            screen[r][c] = v;
    endfunction

    function automatic void widen_dirty();
        if (cur_row < dirty_lo)
            dirty_lo = cur_row;
        if (cur_row > dirty_hi)
            dirty_hi = cur_row;
    endfunction

    function automatic void mark_all_dirty();
        dirty_lo  = 5'd0;
        dirty_hi  = 5'(ROWS - 1);
        full_flag = 1'b1;
    endfunction

    // Everything moves up one row; the bottom row comes in blank.
    function automatic void shift_rows_up();
        for (int r = 0; r < ROWS - 1; r++)
            for (int c = 0; c < ROW_CELLS; c++)
                screen[r][c] = screen[r + 1][c];
        for (int c = 0; c < ROW_CELLS; c++)
            screen[ROWS - 1][c] = 8'd0;
        cur_row = 5'(ROWS - 1);
        mark_all_dirty();
        scroll_count++;
    endfunction

    function automatic void wipe_screen();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < ROW_CELLS; c++)
                screen[r][c] = 8'd0;
        cur_col = '0;
        cur_row = '0;
        mark_all_dirty();
    endfunction

    function automatic void put_byte(input logic [7:0] ch);
        if (cur_row >= ROWS)
            shift_rows_up();
        widen_dirty();
        case (ch)
            CHAR_NEWLINE:
            begin
                cur_col = '0;
                cur_row = cur_row + 5'd1;
            end
            CHAR_RETURN:
            begin
                cur_col = '0;
                for (int c = 0; c < ROW_CELLS; c++)
                    poke(cur_row, c, 8'd0);
            end
            CHAR_BACKSPACE:
            begin
                if (cur_col > 0)
                begin
                    cur_col = cur_col - 6'd1;
                    poke(cur_row, cur_col, 8'd0);
                end
                else if (cur_row > 0)
                begin
                    cur_row = cur_row - 5'd1;
                    cur_col = 6'(COLS - 1);
                    poke(cur_row, cur_col, 8'd0);
                end
            end
            default:
            begin
                if (cur_col >= COLS)
                begin
                    wrap_count++;
                    cur_col = '0;
                    cur_row = cur_row + 5'd1;
                    if (cur_row >= ROWS)
                        shift_rows_up();
                end
                poke(cur_row, cur_col, ch);
                cur_col = cur_col + 6'd1;
                poke(cur_row, cur_col, 8'd0);
            end
        endcase
        widen_dirty();
    endfunction

    // Applies one request to the model and returns the status it reports.
    function automatic status_t console_apply(input logic [1:0] cmd, input logic [7:0] ch,
                                              input logic [4:0] rr, input logic [5:0] rc);
        status_t s;
        s.cell_char = 8'd0;
        case (cmd)
            CMD_PUT:   put_byte(ch);
            CMD_CLEAR: wipe_screen();
            CMD_READ:
            begin
                read_count++;
                if (rr < ROWS && rc < ROW_CELLS)
                    s.cell_char = screen[rr][rc];
            end
            default:
            begin
                if (full_flag)
                begin
                    full_flag = 1'b0;
                    dirty_lo  = 5'd0;
                    dirty_hi  = 5'(ROWS - 1);
                end
                else
                begin
                    dirty_lo = 5'(ROWS);
                    dirty_hi = 5'd0;
                end
            end
        endcase
        s.cursor_col  = cur_col;
        s.cursor_row  = cur_row;
        s.dirty_first = dirty_lo;
        s.dirty_last  = dirty_hi;
        s.redraw_all  = full_flag;
        return s;
    endfunction

    initial
        wipe_screen();

    // ------------------------------------------------------------------
    // Scoreboard: model runs at each accepted request, each result is
    // compared with the oldest status still owed.
    // ------------------------------------------------------------------
    req_note_t note_q   [$];
    status_t   status_q [$];
    int errors        = 0;
    int results_seen  = 0;
    int items_sent    = 0;
    int cycle_count   = 0;

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        req_note_t note;
        status_t   want;
        status_t   got;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                note = note_q.pop_front();
                want = console_apply(s_axis_tuser, s_axis_tdata[7:0],
                                     s_axis_tdata[12:8], s_axis_tdata[18:13]);
                if (note.known)
                    want = note.golden;
                status_q.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                got = m_axis_tdata[29:0];
                if (status_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_field("cursor_col",  want.cursor_col,  got.cursor_col);
                    check_field("cursor_row",  want.cursor_row,  got.cursor_row);
                    check_field("dirty_first", want.dirty_first, got.dirty_first);
                    check_field("dirty_last",  want.dirty_last,  got.dirty_last);
                    check_field("redraw_all",  want.redraw_all,  got.redraw_all);
                    check_field("cell_char",   want.cell_char,   got.cell_char);
                    check_field("tdata pad",   0,                m_axis_tdata[31:30]);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, status_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side back-pressure: a new mode each time rx_phase wraps - always
    // ready, a rotating 16-bit mask, coin flips, or a periodic ready.
    // ------------------------------------------------------------------
    int         rx_phase = 0;
    int         rx_mode  = 0;
    logic [15:0] rx_mask = '1;

    always @(posedge clk)
    begin
        if (rx_phase == 0)
        begin
            rx_mode = $urandom_range(0, 3);
            rx_mask = 16'($urandom);
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= rx_mask[rx_phase % 16];
            2:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            default: m_axis_tready <= ((rx_phase % 8) == 7);
        endcase
        rx_phase = (rx_phase + 1) % 48;
    end

    // ------------------------------------------------------------------
    // Request side: bursts of random length separated by random gaps,
    // with an occasional long burst that keeps tvalid high throughout.
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_req(input logic [1:0] cmd, input logic [7:0] ch,
                            input logic [4:0] rr, input logic [5:0] rc,
                            input logic known, input status_t golden);
        req_note_t note;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        note.known  = known;
        note.golden = golden;
        note_q.push_back(note);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        // unused coordinate fields still carry random bits
        s_axis_tdata  <= {5'd0, rc, rr, ch};
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_put(input logic [7:0] ch);
        send_req(CMD_PUT, ch, 5'($urandom), 6'($urandom), 1'b0, '0);
    endtask

    task automatic send_read();
        logic [4:0] rr;
        logic [5:0] rc;
        // mostly inside the grid, sometimes anywhere in the field range
        if ($urandom_range(0, 4) == 0)
        begin
            rr = 5'($urandom);
            rc = 6'($urandom);
        end
        else
        begin
            rr = 5'($urandom_range(0, ROWS - 1));
            rc = 6'($urandom_range(0, COLS));
        end
        send_req(CMD_READ, 8'($urandom), rr, rc, 1'b0, '0);
    endtask

    function automatic logic [7:0] any_printable();
        logic [7:0] ch;
        do
            ch = 8'($urandom);
        while (ch == CHAR_NEWLINE || ch == CHAR_RETURN || ch == CHAR_BACKSPACE);
        return ch;
    endfunction

    initial
    begin
        int pick;
        int len;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < SCRIPT_LEN; i++)
            send_req(SCRIPT[i].cmd, SCRIPT[i].ch, SCRIPT[i].rrow, SCRIPT[i].rcol,
                     SCRIPT[i].known, SCRIPT[i].golden);

        // Random part, built from phrases of console traffic: text runs long
        // enough to wrap, newline runs that push the cursor past the bottom
        // row, backspace runs that climb rows, reads, redraw handshakes,
        // rare clears and some raw noise.
        while (items_sent < SCRIPT_LEN + RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = $urandom_range(1, 45);
                repeat (len) send_put(any_printable());
                case ($urandom_range(0, 3))
                    0: send_put(CHAR_NEWLINE);
                    1:
                    begin
                        send_put(CHAR_RETURN);
                        send_put(CHAR_NEWLINE);
                    end
                    default: ;
                endcase
            end
            else if (pick < 65)
            begin
                len = $urandom_range(1, 30);
                repeat (len) send_put(CHAR_NEWLINE);
            end
            else if (pick < 75)
            begin
                len = $urandom_range(1, 45);
                repeat (len) send_put(CHAR_BACKSPACE);
            end
            else if (pick < 85)
            begin
                len = $urandom_range(1, 4);
                repeat (len) send_read();
            end
            else if (pick < 92)
            begin
                len = $urandom_range(1, 2);
                repeat (len) send_req(CMD_REDRAW, 8'($urandom), 5'($urandom),
                                      6'($urandom), 1'b0, '0);
            end
            else if (pick < 94)
                send_req(CMD_CLEAR, 8'($urandom), 5'($urandom), 6'($urandom), 1'b0, '0);
            else
                send_req(2'($urandom), 8'($urandom), 5'($urandom), 6'($urandom), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (status_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests %0d, results %0d, reads %0d, errors %0d",
                 items_sent, results_seen, read_count, errors);
        $display("grid scrolled %0d times, cursor wrapped at the right edge %0d times",
                 scroll_count, wrap_count);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== text_console_char_writer_top.f =====
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_char_writer_top.sv
test/tb_text_console_char_writer_top.sv
